/* sv/lgr_pkg.sv */
`timescale 1ns / 1ps
package lgr_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // register reset values
  localparam logic [6:0] GRID_POINTS_RESET = 7'd64;

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // relaxation methods
  localparam logic [1:0] METH_JACOBI = 2'd0;
  localparam logic [1:0] METH_GS     = 2'd1;
  localparam logic [1:0] METH_RB     = 2'd2;
  localparam logic [1:0] METH_NONE   = 2'd3;

  // register indexes
  localparam logic REG_GRID_POINTS = 1'b0;
  localparam logic REG_METHOD      = 1'b1;

endpackage

/* sv/laplace_grid_relaxation.sv */
`timescale 1ns / 1ps
// Laplace grid relaxation engine.
// Input channel (in_valid/in_ready) takes one item: mode selects write point,
// read point, run one relaxation sweep or nop; row/col/value address and carry data.
// Output channel (out_valid/out_ready) gives one item per input item:
// read_value (zero unless a read inside the grid) and the saturating sweep count.
// Registers grid_points (addr 0) and method (addr 4) sit on the APB port.
// A write or read item passes through ST_FIN, which loads its result into the
// output register once that register is free.
// A sweep scans all MAX_POINTS*MAX_POINTS entries of the grid memory once
// (twice for red-black). A point that is updated reads its four neighbors on
// the single memory read port (ST_SCAN, then ST_NB) and writes back their
// average in ST_WR; a Jacobi carry-over point is copied to the other buffer in
// ST_CPY; any other point is only stepped over.
// One item is processed at a time; in_ready is high only while idle.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result waits for the receiver before it is loaded.
// Reset clears the sweep count, buffer select and registers, and needs no
// clearing pass: grid contents are undefined until written.
module laplace_grid_relaxation
  import lgr_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [23:0]        sweeps_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CELLS = MAX_POINTS * MAX_POINTS;
  localparam int AW    = $clog2(2 * CELLS);
  localparam int NW    = PW + 8;
  localparam int VW    = VALUE_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_NB, ST_CPY, ST_WR, ST_FIN
  } state_t;

  state_t state;

  logic signed [VW-1:0] mem [2*CELLS];
  logic signed [VW-1:0] mem_q;

  logic [PW-1:0]        r_cnt;
  logic [PW-1:0]        c_cnt;
  logic                 pass;
  logic [2:0]           k;
  logic signed [VW+1:0] acc;
  logic                 buf_sel;
  logic [23:0]          sweep_cnt;
  logic [6:0]           grid_points;
  logic [1:0]           method;
  logic                 rd_hit;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;

  logic [NW-1:0] rn, cn, n_eff, in_r, in_c, nb_r, nb_c;
  logic          interior, do_upd, last_pt, c_wrap, in_inside, step_done;
  logic [AW-1:0] self_addr, nb_addr, in_addr;

  function automatic logic [AW-1:0] addr_of(input logic s, input logic [NW-1:0] r,
                                            input logic [NW-1:0] c);
    int a;
    a = (s ? CELLS : 0) + int'(r) * MAX_POINTS + int'(c);
    return AW'(a);
  endfunction

  // scan position and point class
  always_comb begin
    rn        = NW'(r_cnt);
    cn        = NW'(c_cnt);
    n_eff     = (NW'(grid_points) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(grid_points);
    interior  = (rn >= NW'(1)) && (cn >= NW'(1)) &&
                (rn + NW'(1) < n_eff) && (cn + NW'(1) < n_eff);
    do_upd    = interior && ((method == METH_JACOBI) || (method == METH_GS) ||
                ((method == METH_RB) && ((r_cnt[0] ^ c_cnt[0]) == pass)));
    c_wrap    = (c_cnt == PW'(MAX_POINTS - 1));
    last_pt   = (r_cnt == PW'(MAX_POINTS - 1)) && c_wrap;
    in_r      = NW'(row);
    in_c      = NW'(col);
    in_inside = (in_r < NW'(MAX_POINTS)) && (in_c < NW'(MAX_POINTS));
    in_addr   = addr_of(buf_sel, in_r, in_c);
    self_addr = addr_of(buf_sel, rn, cn);
    step_done = ((state == ST_SCAN) && !do_upd && (method != METH_JACOBI)) ||
                (state == ST_CPY) || (state == ST_WR);
  end

  // neighbor select: below, above, left, right
  always_comb begin
    nb_r = rn;
    nb_c = cn;
    case (k[1:0])
      2'd0:    nb_r = rn + NW'(1);
      2'd1:    nb_r = rn - NW'(1);
      2'd2:    nb_c = cn - NW'(1);
      default: nb_c = cn + NW'(1);
    endcase
    nb_addr = addr_of(buf_sel, nb_r, nb_c);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = nb_addr;
    we      = 1'b0;
    wr_addr = in_addr;
    wr_data = VW'(value);
    unique case (state)
      ST_IDLE: begin
        rd_en   = in_valid && (mode == MODE_READ) && in_inside;
        rd_addr = in_addr;
        we      = in_valid && (mode == MODE_WRITE) && in_inside;
      end
      ST_SCAN: begin
        if (do_upd) begin
          rd_en = 1'b1;
        end else if (method == METH_JACOBI) begin
          rd_en   = 1'b1;
          rd_addr = self_addr;
        end
      end
      ST_NB: begin
        rd_en = (k != 3'd4);
      end
      ST_CPY: begin
        we      = 1'b1;
        wr_addr = addr_of(~buf_sel, rn, cn);
        wr_data = mem_q;
      end
      ST_WR: begin
        we      = 1'b1;
        wr_addr = addr_of((method == METH_JACOBI) ? ~buf_sel : buf_sel, rn, cn);
        wr_data = VW'(acc >>> 2);
      end
      default: ;
    endcase
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign pready   = 1'b1;

  // register read
  always_comb begin
    unique case (paddr[2])
      REG_GRID_POINTS: prdata = {25'd0, grid_points};
      REG_METHOD:      prdata = {30'd0, method};
      default:         prdata = 32'd0;
    endcase
  end

  // control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      buf_sel     <= 1'b0;
      sweep_cnt   <= 24'd0;
      grid_points <= GRID_POINTS_RESET;
      method      <= METH_JACOBI;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_GRID_POINTS: grid_points <= pwdata[6:0];
          REG_METHOD:      method      <= pwdata[1:0];
          default:         ;
        endcase
      end
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rd_hit <= (mode == MODE_READ) && in_inside;
            r_cnt  <= '0;
            c_cnt  <= '0;
            pass   <= 1'b0;
            k      <= 3'd0;
            state  <= (mode == MODE_SWEEP) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          acc <= '0;
          if (do_upd) begin
            k     <= 3'd1;
            state <= ST_NB;
          end else if (method == METH_JACOBI) begin
            state <= ST_CPY;
          end
        end
        ST_NB: begin
          acc <= acc + (VW+2)'(mem_q);
          if (k == 3'd4) begin
            state <= ST_WR;
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_CPY, ST_WR: ;
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            read_value  <= rd_hit ? 32'(mem_q) : 32'sd0;
            sweeps_done <= sweep_cnt;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // advance the scan after a point is finished
      if (step_done) begin
        k <= 3'd0;
        if (last_pt) begin
          r_cnt <= '0;
          c_cnt <= '0;
          if ((method == METH_RB) && !pass) begin
            pass  <= 1'b1;
            state <= ST_SCAN;
          end else begin
            if (sweep_cnt != 24'hFFFFFF) begin
              sweep_cnt <= sweep_cnt + 24'd1;
            end
            if (method == METH_JACOBI) begin
              buf_sel <= ~buf_sel;
            end
            rd_hit <= 1'b0;
            state  <= ST_FIN;
          end
        end else begin
          if (c_wrap) begin
            c_cnt <= '0;
            r_cnt <= r_cnt + PW'(1);
          end else begin
            c_cnt <= c_cnt + PW'(1);
          end
          state <= ST_SCAN;
        end
      end
    end
  end

  // sweep count only grows
  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> sweep_cnt >= $past(sweep_cnt))
    else $error("sweep count decreased");

  // buffers swap only at the end of a jacobi sweep
  a_swap: assert property (@(posedge clk) disable iff (rst)
    (buf_sel != $past(buf_sel)) |->
      (($past(state) == ST_SCAN) || ($past(state) == ST_CPY) || ($past(state) == ST_WR)) &&
      ($past(method) == METH_JACOBI))
    else $error("buffer swap outside jacobi sweep end");

  // a relaxed point is written only after all four neighbor reads
  a_wr_after_nb: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> ($past(state) == ST_NB) && ($past(k) == 3'd4))
    else $error("write-back without four neighbors");

endmodule
